[hdl/bsc_pkg.sv]
// Shared constants for the barometer compensation pipeline.
package bsc_pkg;

	localparam int DIV_W = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B1_B2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MC_MD   = 3'd4;

	localparam logic [31:0] K_B6_OFFSET = 32'd4000;
	localparam logic [31:0] K_B7_SCALE  = 32'd50000;
	localparam logic [31:0] K_SIGN      = 32'h8000_0000;
	localparam logic [31:0] K_P_SQ      = 32'd3038;
	localparam logic [31:0] K_P_LIN     = 32'hFFFF_E343;
	localparam logic [31:0] K_P_OFS     = 32'd3791;
	localparam logic [31:0] K_B4_OFS    = 32'd32768;

	localparam logic signed [31:0] T_MAX = 32'sd32767;
	localparam logic signed [31:0] T_MIN = -32'sd32768;
	localparam logic signed [31:0] P_MAX = 32'sd262143;

endpackage

[hdl/bsc_div.sv]
// Pipelined restoring unsigned divider, one quotient bit per stage.
module bsc_div import bsc_pkg::*; #(
	parameter int WIDTH  = DIV_W,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [WIDTH-1:0]  in_num,
	input  logic [WIDTH-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [WIDTH-1:0]  out_quo,
	output logic [SIDE_W-1:0] out_side
);

	logic              vld_s  [WIDTH];
	logic [WIDTH-1:0]  num_s  [WIDTH];
	logic [WIDTH-1:0]  rem_s  [WIDTH];
	logic [WIDTH-1:0]  den_s  [WIDTH];
	logic [SIDE_W-1:0] side_s [WIDTH];

	for (genvar g = 0; g < WIDTH; g++) begin : g_stage
		logic              v_in;
		logic [WIDTH-1:0]  n_in, r_in, d_in;
		logic [SIDE_W-1:0] s_in;
		logic [WIDTH:0]    trial;

		if (g == 0) begin : g_first
			assign v_in = in_valid;
			assign n_in = in_num;
			assign r_in = '0;
			assign d_in = in_den;
			assign s_in = in_side;
		end else begin : g_next
			assign v_in = vld_s[g-1];
			assign n_in = num_s[g-1];
			assign r_in = rem_s[g-1];
			assign d_in = den_s[g-1];
			assign s_in = side_s[g-1];
		end

		// trial subtract of the shifted remainder; borrow means quotient bit zero
		assign trial = {r_in, n_in[WIDTH-1]} - {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g]  <= trial[WIDTH] ? {r_in[WIDTH-2:0], n_in[WIDTH-1]} : trial[WIDTH-1:0];
			num_s[g]  <= {n_in[WIDTH-2:0], ~trial[WIDTH]};
			den_s[g]  <= d_in;
			side_s[g] <= s_in;
		end
	end

	assign out_valid = vld_s[WIDTH-1];
	assign out_quo   = num_s[WIDTH-1];
	assign out_side  = side_s[WIDTH-1];

endmodule

[hdl/baro_sensor_compensation.sv]
// Top level: barometer temperature and pressure compensation pipeline.
//
// Usage: load the five calibration words through cfg_wr_en / cfg_index /
// cfg_wdata while no reading is in flight; writes to an index past the
// last register are dropped. A reading pair is transferred at each clock
// edge where start is high and busy is low. busy never rises, so one pair
// can enter every cycle.
// Each reading produces one result, shown for exactly one cycle with done
// high. The pipeline is made of the two 32-stage divider pipelines
// (temperature divisor and pressure divisor) plus fifteen arithmetic
// stages; throughput is one reading per cycle.
// calc_error flags a zero divisor, and both values are then zero.
// Reset clears all valid bits and the calibration words; no result is
// produced until a reading is transferred. The receiver cannot stall, so
// results are never held back.
module baro_sensor_compensation import bsc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_wdata,
	input  logic                 start,
	output logic                 busy,
	input  logic [15:0]          raw_temperature,
	input  logic [15:0]          raw_pressure,
	output logic                 done,
	output logic signed [15:0]   temperature_decidegrees,
	output logic [17:0]          pressure_pascal,
	output logic                 calc_error
);

	logic [31:0] ac1_ac2_q, ac3_ac4_q, ac5_ac6_q, b1_b2_q, mc_md_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac1_ac2_q <= '0;
			ac3_ac4_q <= '0;
			ac5_ac6_q <= '0;
			b1_b2_q   <= '0;
			mc_md_q   <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_AC1_AC2: ac1_ac2_q <= cfg_wdata;
				REG_AC3_AC4: ac3_ac4_q <= cfg_wdata;
				REG_AC5_AC6: ac5_ac6_q <= cfg_wdata;
				REG_B1_B2:   b1_b2_q   <= cfg_wdata;
				REG_MC_MD:   mc_md_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = {{16{ac1_ac2_q[31]}}, ac1_ac2_q[31:16]};
	assign ac2 = {{16{ac1_ac2_q[15]}}, ac1_ac2_q[15:0]};
	assign ac3 = {{16{ac3_ac4_q[31]}}, ac3_ac4_q[31:16]};
	assign ac4 = {16'd0, ac3_ac4_q[15:0]};
	assign ac5 = {16'd0, ac5_ac6_q[31:16]};
	assign ac6 = {16'd0, ac5_ac6_q[15:0]};
	assign b1  = {{16{b1_b2_q[31]}}, b1_b2_q[31:16]};
	assign b2  = {{16{b1_b2_q[15]}}, b1_b2_q[15:0]};
	assign mc  = {{16{mc_md_q[31]}}, mc_md_q[31:16]};
	assign md  = {{16{mc_md_q[15]}}, mc_md_q[15:0]};

	assign busy = 1'b0;

	logic accept;
	assign accept = start & ~busy;

	// stage 1: temperature raw product
	logic        vld_s1;
	logic [31:0] prod_s1;
	logic [15:0] up_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 32'(({16'd0, raw_temperature} - ac6) * ac5);
		up_s1   <= raw_pressure;
	end

	// stage 2: temperature divisor setup, signed to magnitudes
	logic        vld_s2;
	logic [31:0] x1t_s2, num_s2, den_s2;
	logic [15:0] up_s2;
	logic        negq_s2, err_s2;
	logic [31:0] x1t, den, numt;

	assign x1t  = 32'($signed(prod_s1) >>> 15);
	assign den  = x1t + md;
	assign numt = mc << 11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		x1t_s2  <= x1t;
		num_s2  <= numt[31] ? 32'(0 - numt) : numt;
		den_s2  <= den[31] ? 32'(0 - den) : den;
		negq_s2 <= numt[31] ^ den[31];
		err_s2  <= (den == '0);
		up_s2   <= up_s1;
	end

	localparam int SIDE1_W = 32 + 16 + 2;
	logic               dv1_vld;
	logic [31:0]        dv1_quo;
	logic [SIDE1_W-1:0] dv1_side;

	bsc_div #(.WIDTH(DIV_W), .SIDE_W(SIDE1_W)) u_div_temp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s2),
		.in_num   (num_s2),
		.in_den   (den_s2),
		.in_side  ({x1t_s2, up_s2, negq_s2, err_s2}),
		.out_valid(dv1_vld),
		.out_quo  (dv1_quo),
		.out_side (dv1_side)
	);

	// stage 3: B5
	logic        vld_s3, err_s3;
	logic [31:0] b5_s3;
	logic [15:0] up_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else vld_s3 <= dv1_vld;
	end

	always_ff @(posedge clk) begin
		b5_s3  <= dv1_side[49:18] + (dv1_side[1] ? 32'(0 - dv1_quo) : dv1_quo);
		up_s3  <= dv1_side[17:2];
		err_s3 <= dv1_side[0];
	end

	// stage 4: temperature (saturated) and B6
	logic               vld_s4, err_s4;
	logic signed [15:0] t_s4;
	logic [31:0]        b6_s4;
	logic [15:0]        up_s4;
	logic signed [31:0] t32;

	assign t32 = $signed(b5_s3 + 32'd8) >>> 4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (t32 > T_MAX) t_s4 <= 16'sh7FFF;
		else if (t32 < T_MIN) t_s4 <= -16'sh8000;
		else t_s4 <= t32[15:0];
		b6_s4  <= b5_s3 - K_B6_OFFSET;
		up_s4  <= up_s3;
		err_s4 <= err_s3;
	end

	// stage 5: products of B6
	logic               vld_s5, err_s5;
	logic signed [15:0] t_s5;
	logic [31:0]        sqr_s5, ac2b6_s5, ac3b6_s5;
	logic [15:0]        up_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		sqr_s5   <= 32'(b6_s4 * b6_s4);
		ac2b6_s5 <= 32'(ac2 * b6_s4);
		ac3b6_s5 <= 32'(ac3 * b6_s4);
		t_s5     <= t_s4;
		up_s5    <= up_s4;
		err_s5   <= err_s4;
	end

	// stage 6: scale
	logic               vld_s6, err_s6;
	logic signed [15:0] t_s6;
	logic [31:0]        sq_s6, x2a_s6, x1c_s6;
	logic [15:0]        up_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		sq_s6  <= 32'($signed(sqr_s5) >>> 12);
		x2a_s6 <= 32'($signed(ac2b6_s5) >>> 11);
		x1c_s6 <= 32'($signed(ac3b6_s5) >>> 13);
		t_s6   <= t_s5;
		up_s6  <= up_s5;
		err_s6 <= err_s5;
	end

	// stage 7: B2 and B1 terms
	logic               vld_s7, err_s7;
	logic signed [15:0] t_s7;
	logic [31:0]        m1_s7, m2_s7, x2a_s7, x1c_s7;
	logic [15:0]        up_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		m1_s7  <= 32'(b2 * sq_s6);
		m2_s7  <= 32'(b1 * sq_s6);
		x2a_s7 <= x2a_s6;
		x1c_s7 <= x1c_s6;
		t_s7   <= t_s6;
		up_s7  <= up_s6;
		err_s7 <= err_s6;
	end

	// stage 8: B3 and the B4 factor
	logic               vld_s8, err_s8;
	logic signed [15:0] t_s8;
	logic [31:0]        b3_s8, f4_s8;
	logic [15:0]        up_s8;
	logic [31:0]        x1b, x3b, x2c, x3c;

	assign x1b = 32'($signed(m1_s7) >>> 11);
	assign x3b = x1b + x2a_s7;
	assign x2c = 32'($signed(m2_s7) >>> 16);
	assign x3c = 32'($signed(x1c_s7 + x2c + 32'd2) >>> 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		b3_s8  <= 32'($signed((ac1 << 2) + x3b + 32'd2) >>> 2);
		f4_s8  <= x3c + K_B4_OFS;
		t_s8   <= t_s7;
		up_s8  <= up_s7;
		err_s8 <= err_s7;
	end

	// stage 9: B4 and UP - B3
	logic               vld_s9, err_s9;
	logic signed [15:0] t_s9;
	logic [31:0]        b4_s9, d7_s9;
	logic [31:0]        p4;

	assign p4 = 32'(ac4 * f4_s8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s9 <= 1'b0;
		else vld_s9 <= vld_s8;
	end

	always_ff @(posedge clk) begin
		b4_s9  <= p4 >> 15;
		d7_s9  <= {16'd0, up_s8} - b3_s8;
		t_s9   <= t_s8;
		err_s9 <= err_s8;
	end

	// stage 10: B7
	logic               vld_s10, err_s10;
	logic signed [15:0] t_s10;
	logic [31:0]        b4_s10, b7_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s10 <= 1'b0;
		else vld_s10 <= vld_s9;
	end

	always_ff @(posedge clk) begin
		b7_s10  <= 32'(d7_s9 * K_B7_SCALE);
		b4_s10  <= b4_s9;
		t_s10   <= t_s9;
		err_s10 <= err_s9 | (b4_s9 == '0);
	end

	// stage 11: pressure divisor setup
	logic               vld_s11, err_s11, shl_s11;
	logic signed [15:0] t_s11;
	logic [31:0]        num_s11, den_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s11 <= 1'b0;
		else vld_s11 <= vld_s10;
	end

	always_ff @(posedge clk) begin
		shl_s11 <= (b7_s10 >= K_SIGN);
		num_s11 <= (b7_s10 >= K_SIGN) ? b7_s10 : {b7_s10[30:0], 1'b0};
		den_s11 <= b4_s10;
		t_s11   <= t_s10;
		err_s11 <= err_s10;
	end

	localparam int SIDE2_W = 16 + 2;
	logic               dv2_vld;
	logic [31:0]        dv2_quo;
	logic [SIDE2_W-1:0] dv2_side;

	bsc_div #(.WIDTH(DIV_W), .SIDE_W(SIDE2_W)) u_div_pres (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s11),
		.in_num   (num_s11),
		.in_den   (den_s11),
		.in_side  ({t_s11, shl_s11, err_s11}),
		.out_valid(dv2_vld),
		.out_quo  (dv2_quo),
		.out_side (dv2_side)
	);

	// stage 12: raw pressure
	logic               vld_s12, err_s12;
	logic signed [15:0] t_s12;
	logic [31:0]        p_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s12 <= 1'b0;
		else vld_s12 <= dv2_vld;
	end

	always_ff @(posedge clk) begin
		p_s12   <= dv2_side[1] ? {dv2_quo[30:0], 1'b0} : dv2_quo;
		t_s12   <= dv2_side[17:2];
		err_s12 <= dv2_side[0];
	end

	// stage 13: correction products
	logic               vld_s13, err_s13;
	logic signed [15:0] t_s13;
	logic [31:0]        p_s13, psq_s13, plin_s13;
	logic [31:0]        p8;

	assign p8 = 32'($signed(p_s12) >>> 8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s13 <= 1'b0;
		else vld_s13 <= vld_s12;
	end

	always_ff @(posedge clk) begin
		psq_s13  <= 32'(p8 * p8);
		plin_s13 <= 32'(K_P_LIN * p_s12);
		p_s13    <= p_s12;
		t_s13    <= t_s12;
		err_s13  <= err_s12;
	end

	// stage 14: square term
	logic               vld_s14, err_s14;
	logic signed [15:0] t_s14;
	logic [31:0]        p_s14, m3_s14, x2p_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s14 <= 1'b0;
		else vld_s14 <= vld_s13;
	end

	always_ff @(posedge clk) begin
		m3_s14  <= 32'(psq_s13 * K_P_SQ);
		x2p_s14 <= 32'($signed(plin_s13) >>> 16);
		p_s14   <= p_s13;
		t_s14   <= t_s13;
		err_s14 <= err_s13;
	end

	// stage 15: final pressure, clamp, result register
	logic [31:0]        x1p, pf;
	logic signed [31:0] pfs;
	logic [17:0]        pclamp;

	assign x1p = 32'($signed(m3_s14) >>> 16);
	assign pf  = p_s14 + 32'($signed(x1p + x2p_s14 + K_P_OFS) >>> 4);
	assign pfs = $signed(pf);

	always_comb begin
		if (pfs > P_MAX) pclamp = P_MAX[17:0];
		else if (pfs < 0) pclamp = '0;
		else pclamp = pf[17:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_s14;
	end

	always_ff @(posedge clk) begin
		temperature_decidegrees <= err_s14 ? 16'sd0 : t_s14;
		pressure_pascal         <= err_s14 ? 18'd0 : pclamp;
		calc_error              <= err_s14;
	end

endmodule

[tb/sv/tb_baro_sensor_compensation.sv]
// Self-checking testbench for the barometer compensation pipeline.
module tb_baro_sensor_compensation;
	import bsc_pkg::*;

	localparam int PIPE_LAT   = 79;
	localparam int IDLE_LIMIT = 5000;
	localparam int RAND_PHASES = 15;
	localparam int PHASE_ITEMS = 110;

	typedef struct {
		logic signed [15:0] temp;
		logic [17:0]        pres;
		logic               err;
	} reading_t;

	typedef struct {
		int          cal_sel;
		logic [15:0] ut;
		logic [15:0] up;
		bit          typed;
		reading_t    want;
	} stim_row_t;

	typedef logic [31:0] cal_set_t [5];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_AC1_AC2;
	logic [31:0] cfg_wdata = '0;
	logic start = 1'b0;
	logic busy;
	logic [15:0] raw_temperature = '0;
	logic [15:0] raw_pressure = '0;
	logic done;
	logic signed [15:0] temperature_decidegrees;
	logic [17:0] pressure_pascal;
	logic calc_error;

	logic [31:0] cal [5] = '{default: '0};
	reading_t pending_readings [$];
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	// Calibration sets: reset, datasheet, pressure divisor zero, all ones, min, max
	const cal_set_t cal_sets [6] = '{
		'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
		'{32'h0198FFB8, 32'hC7D17FE5, 32'h7FF55A71, 32'h182E0004, 32'hDDF90B34},
		'{32'h0, 32'h0, 32'h0, 32'h0, 32'h00000001},
		'{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
		'{32'h80008000, 32'h80008000, 32'h80008000, 32'h80008000, 32'h80008000},
		'{32'h7FFF7FFF, 32'h7FFF7FFF, 32'h7FFF7FFF, 32'h7FFF7FFF, 32'h7FFF7FFF}
	};

	localparam reading_t zero_err = '{temp: '0, pres: '0, err: 1'b1};
	localparam reading_t no_value = '{temp: '0, pres: '0, err: 1'b0};

	const stim_row_t directed_rows [20] = '{
		'{0, 16'h0000, 16'h0000, 1'b1, zero_err},
		'{0, 16'hFFFF, 16'hFFFF, 1'b1, zero_err},
		'{0, 16'h8000, 16'h0001, 1'b1, zero_err},
		'{1, 16'd27898, 16'd23843, 1'b0, no_value},
		'{1, 16'h0000, 16'h0000, 1'b0, no_value},
		'{1, 16'hFFFF, 16'hFFFF, 1'b0, no_value},
		'{1, 16'h7FFF, 16'h8000, 1'b0, no_value},
		'{1, 16'h8000, 16'h7FFF, 1'b0, no_value},
		'{2, 16'h0000, 16'h0000, 1'b1, zero_err},
		'{2, 16'hFFFF, 16'hFFFF, 1'b1, zero_err},
		'{2, 16'h5555, 16'hAAAA, 1'b1, zero_err},
		'{3, 16'h0000, 16'h0000, 1'b0, no_value},
		'{3, 16'hFFFF, 16'hFFFF, 1'b0, no_value},
		'{3, 16'hAAAA, 16'h5555, 1'b0, no_value},
		'{4, 16'h0000, 16'hFFFF, 1'b0, no_value},
		'{4, 16'hFFFF, 16'h0000, 1'b0, no_value},
		'{4, 16'h8000, 16'h8000, 1'b0, no_value},
		'{5, 16'h0000, 16'hFFFF, 1'b0, no_value},
		'{5, 16'hFFFF, 16'h0000, 1'b0, no_value},
		'{5, 16'h1234, 16'hFEDC, 1'b0, no_value}
	};

	bit expect_typed = 1'b0;
	reading_t typed_want = no_value;

	baro_sensor_compensation dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.raw_temperature(raw_temperature),
		.raw_pressure(raw_pressure),
		.done(done),
		.temperature_decidegrees(temperature_decidegrees),
		.pressure_pascal(pressure_pascal),
		.calc_error(calc_error)
	);

	always #2 clk = ~clk;

	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sra(input logic [31:0] v, input int s);
		return $unsigned($signed(v) >>> s);
	endfunction

	// Signed quotient truncated toward zero, wrapping on overflow
	function automatic logic [31:0] squot(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ma, mb, q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	function automatic reading_t compensate(input logic [15:0] ut_in, input logic [15:0] up_in);
		logic [31:0] ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] x1, x2, x3, den, b3, b4, b5, b6, b7, sq, t, p;
		reading_t r;
		r = zero_err;
		ut = {16'h0, ut_in};
		up = {16'h0, up_in};
		ac1 = sext16(cal[REG_AC1_AC2][31:16]);
		ac2 = sext16(cal[REG_AC1_AC2][15:0]);
		ac3 = sext16(cal[REG_AC3_AC4][31:16]);
		ac4 = {16'h0, cal[REG_AC3_AC4][15:0]};
		ac5 = {16'h0, cal[REG_AC5_AC6][31:16]};
		ac6 = {16'h0, cal[REG_AC5_AC6][15:0]};
		b1 = sext16(cal[REG_B1_B2][31:16]);
		b2 = sext16(cal[REG_B1_B2][15:0]);
		mc = sext16(cal[REG_MC_MD][31:16]);
		md = sext16(cal[REG_MC_MD][15:0]);

		x1 = sra((ut - ac6) * ac5, 15);
		den = x1 + md;
		if (den == '0)
			return r;
		x2 = squot(mc << 11, den);
		b5 = x1 + x2;
		t = sra(b5 + 32'd8, 4);

		b6 = b5 - K_B6_OFFSET;
		sq = sra(b6 * b6, 12);
		x1 = sra(b2 * sq, 11);
		x2 = sra(ac2 * b6, 11);
		x3 = x1 + x2;
		b3 = sra(ac1 * 32'd4 + x3 + 32'd2, 2);
		x1 = sra(ac3 * b6, 13);
		x2 = sra(b1 * sq, 16);
		x3 = sra(x1 + x2 + 32'd2, 2);
		b4 = (ac4 * (x3 + K_B4_OFS)) >> 15;
		if (b4 == '0)
			return r;
		b7 = (up - b3) * K_B7_SCALE;
		if (b7 < K_SIGN)
			p = (b7 * 32'd2) / b4;
		else
			p = (b7 / b4) << 1;

		x1 = sra(p, 8);
		x1 = x1 * x1;
		x1 = sra(x1 * K_P_SQ, 16);
		x2 = sra(K_P_LIN * p, 16);
		p = p + sra(x1 + x2 + K_P_OFS, 4);

		if ($signed(t) > T_MAX)
			r.temp = T_MAX[15:0];
		else if ($signed(t) < T_MIN)
			r.temp = T_MIN[15:0];
		else
			r.temp = t[15:0];
		if ($signed(p) > P_MAX)
			r.pres = P_MAX[17:0];
		else if ($signed(p) < 0)
			r.pres = '0;
		else
			r.pres = p[17:0];
		r.err = 1'b0;
		return r;
	endfunction

	// Wait for the pipeline to drain before touching calibration
	task automatic drain();
		wait (pending_readings.size() == 0);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	task automatic load_cal(input cal_set_t words);
		for (int i = 0; i < 6; i++) begin
			@(negedge clk);
			cfg_wr_en = 1'b1;
			if (i < 5) begin
				cfg_index = CFG_IDX_W'(i);
				cfg_wdata = words[i];
				cal[i] = words[i];
			end else begin
				// out-of-range index must be dropped
				cfg_index = REG_MC_MD + CFG_IDX_W'($urandom_range(1, 3));
				cfg_wdata = $urandom;
			end
		end
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic send_reading(input logic [15:0] ut, input logic [15:0] up);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				start = 1'b0;
				raw_temperature = 16'($urandom);
				raw_pressure = 16'($urandom);
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		@(negedge clk);
		start = 1'b1;
		raw_temperature = ut;
		raw_pressure = up;
		do @(posedge clk); while (busy);
		burst_left--;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		start = 1'b0;
		burst_left = 0;
	endtask

	// Record transfers, compare typed rows against the predictor, and check results
	always @(posedge clk) begin
		reading_t want;
		reading_t pred;
		if (start && !busy) begin
			pred = compensate(raw_temperature, raw_pressure);
			pending_readings.push_back(pred);
			if (expect_typed && (pred.temp !== typed_want.temp ||
					pred.pres !== typed_want.pres || pred.err !== typed_want.err)) begin
				$error("typed row: expected temp %0d pres %0d err %0d, predicted %0d %0d %0d",
					typed_want.temp, typed_want.pres, typed_want.err,
					pred.temp, pred.pres, pred.err);
				errors++;
			end
		end
		if (done) begin
			if (pending_readings.size() == 0) begin
				$error("unexpected result: temp %0d pres %0d err %0d",
					temperature_decidegrees, pressure_pascal, calc_error);
				errors++;
			end else begin
				want = pending_readings.pop_front();
				if (temperature_decidegrees !== want.temp) begin
					$error("temperature_decidegrees: expected %0d, got %0d",
						want.temp, temperature_decidegrees);
					errors++;
				end
				if (pressure_pascal !== want.pres) begin
					$error("pressure_pascal: expected %0d, got %0d", want.pres, pressure_pascal);
					errors++;
				end
				if (calc_error !== want.err) begin
					$error("calc_error: expected %0d, got %0d", want.err, calc_error);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer or result
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int cur_sel;
		int pick;
		cal_set_t words;
		logic [15:0] ut, up;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		cur_sel = 0;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].cal_sel != cur_sel) begin
				stop_sending();
				expect_typed = 1'b0;
				drain();
				cur_sel = directed_rows[i].cal_sel;
				load_cal(cal_sets[cur_sel]);
			end
			@(negedge clk);
			expect_typed = directed_rows[i].typed;
			typed_want = directed_rows[i].want;
			start = 1'b1;
			raw_temperature = directed_rows[i].ut;
			raw_pressure = directed_rows[i].up;
			do @(posedge clk); while (busy);
		end
		stop_sending();
		expect_typed = 1'b0;

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			pick = $urandom_range(0, 3);
			for (int w = 0; w < 5; w++) begin
				case (pick)
					0: words[w] = cal_sets[1][w] ^ ($urandom & 32'h00FF00FF);
					1: words[w] = $urandom;
					2: words[w] = cal_sets[$urandom_range(3, 5)][w];
					default: words[w] = cal_sets[1][w];
				endcase
			end
			load_cal(words);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					ut = 16'($urandom_range(20000, 35000));
					up = 16'($urandom_range(15000, 45000));
				end else if (pick < 9) begin
					ut = 16'($urandom);
					up = 16'($urandom);
				end else begin
					ut = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					up = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				end
				send_reading(ut, up);
			end
			stop_sending();
		end

		drain();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[filelist.f]
hdl/bsc_pkg.sv
hdl/bsc_div.sv
hdl/baro_sensor_compensation.sv
tb/sv/tb_baro_sensor_compensation.sv
